// ===== rtl/lcacc_pkg.sv =====
// shared types and constants for the label centroid accumulator
// no dependencies; used by lcacc_div and label_centroid_accumulator

package lcacc_pkg;

  localparam int LABEL_W = 10;
  localparam int COORD_W = 12;
  localparam int SUM_W   = 36;
  localparam int COUNT_W = 25;
  localparam int ORDER_W = 10;
  localparam int REQ_W   = 2;

  localparam logic [REQ_W-1:0] REQ_ACC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_CAP = 25'h1000000;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum_y;
    logic [SUM_W-1:0]   sum_x;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_cmd_t;

endpackage

// ===== rtl/lcacc_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module lcacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lcacc_div.sv =====
// restoring divider, one quotient bit per cycle, twelve-bit quotient
// depends on lcacc_pkg; dividend must be below divisor times 4096

module lcacc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  lcacc_pkg::div_cmd_t                 cmd,
  output logic                                done,
  output logic [lcacc_pkg::COORD_W-1:0]       quotient
);

  localparam int QW = lcacc_pkg::COORD_W;
  localparam int CW = lcacc_pkg::COUNT_W;
  localparam int HW = lcacc_pkg::SUM_W - QW;

  logic                 busy;
  logic [3:0]           step;
  logic [CW-1:0]        rem;
  logic [CW-1:0]        dvs;
  logic [QW-1:0]        low;
  logic [CW:0]          trial;
  logic                 fits;

  assign trial = {rem, low[QW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= CW'(cmd.dividend[lcacc_pkg::SUM_W-1 -: HW]);
        low  <= cmd.dividend[QW-1:0];
        dvs  <= cmd.divisor;
      end else if (busy) begin
        if (fits) begin
          rem      <= CW'(trial - {1'b0, dvs});
          quotient <= {quotient[QW-2:0], 1'b1};
        end else begin
          rem      <= trial[CW-1:0];
          quotient <= {quotient[QW-2:0], 1'b0};
        end
        low  <= {low[QW-2:0], 1'b0};
        step <= step + 4'd1;
        if (step == 4'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/label_centroid_accumulator.sv =====
// top level: request decode, sequencer, label table and result register
// depends on lcacc_pkg, lcacc_ram and lcacc_div

// Per-label statistics over a raster-scanned labelled image. An accumulate
// request does a table read, then a read-modify-write of the entry. A read of
// a present label does a table read, then the shared twelve-step divider runs
// for the x centroid and again for the y centroid, then the result is loaded
// into the output register; a read of an absent label skips the divider and
// one of a zero or out-of-range label goes straight to the output register.
// After reset and after each clear request the table is swept to zero, one
// entry per cycle, over all NUM_LABELS entries, during which no request is
// taken. Ignored and unused requests leave the sequencer idle. A finished
// result waits in the output register while the next request is taken; a
// further result holds the sequencer until the waiting one has left.

module label_centroid_accumulator #(
  parameter int NUM_LABELS = 1023,
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // label, x_pos, y_pos, zero fill
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // order_number, pixel_count, center_x, center_y, zero fill
  output logic        m_tuser    // present
);

  localparam int LW = lcacc_pkg::LABEL_W;
  localparam int XW = lcacc_pkg::COORD_W;
  localparam int SW = lcacc_pkg::SUM_W;
  localparam int CW = lcacc_pkg::COUNT_W;
  localparam int OW = lcacc_pkg::ORDER_W;
  localparam int AW = NUM_LABELS > 1 ? $clog2(NUM_LABELS) : 1;
  localparam int IW = AW > LW ? AW : LW;
  localparam int EW = $bits(lcacc_pkg::entry_t);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_ACC_WAIT = 3'd2;
  localparam logic [2:0] S_RD_WAIT  = 3'd3;
  localparam logic [2:0] S_DIV_X    = 3'd4;
  localparam logic [2:0] S_DIV_Y    = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0]            state;
  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         idx_r;
  logic [OW-1:0]         next_order;
  logic [XW-1:0]         in_x_r;
  logic [XW-1:0]         in_y_r;

  logic [LW-1:0]         in_label;
  logic [XW-1:0]         in_x;
  logic [XW-1:0]         in_y;
  logic [IW-1:0]         in_idx;
  logic                  label_ok;
  logic                  frame_ok;
  logic                  accept;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  lcacc_pkg::entry_t     ram_wdata;
  lcacc_pkg::entry_t     ram_rdata;
  logic [EW-1:0]         ram_rbits;

  lcacc_pkg::div_cmd_t   div_cmd;
  logic                  div_done;
  logic [XW-1:0]         div_q;

  logic                  pres_r;
  logic [OW-1:0]         ord_r;
  logic [CW-1:0]         cnt_r;
  logic [SW-1:0]         sum_y_r;
  logic [XW-1:0]         cx_r;
  logic [XW-1:0]         cy_r;

  assign in_label = s_tdata[LW-1:0];
  assign in_x     = s_tdata[LW +: XW];
  assign in_y     = s_tdata[LW+XW +: XW];
  assign in_idx   = IW'(in_label) - IW'(1);
  assign label_ok = (in_label != '0) && (17'(in_label) <= 17'(NUM_LABELS));
  assign frame_ok = (17'(in_x) < 17'(MAX_WIDTH)) && (17'(in_y) < 17'(MAX_HEIGHT));
  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign ram_rdata = lcacc_pkg::entry_t'(ram_rbits);

  // table write port: clearing sweep or accumulate write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (state == S_ACC_WAIT && ram_rdata.count < lcacc_pkg::COUNT_CAP) begin
      ram_we          = 1'b1;
      ram_wdata.sum_x = ram_rdata.sum_x + SW'(in_x_r);
      ram_wdata.sum_y = ram_rdata.sum_y + SW'(in_y_r);
      ram_wdata.count = ram_rdata.count + CW'(1);
      ram_wdata.order = (ram_rdata.count == '0) ? next_order : ram_rdata.order;
    end
  end

  // divider commands: x on the table read, y once x is done
  always_comb begin
    div_cmd = '0;
    if (state == S_RD_WAIT && ram_rdata.count != '0) begin
      div_cmd.start    = 1'b1;
      div_cmd.dividend = ram_rdata.sum_x;
      div_cmd.divisor  = ram_rdata.count;
    end else if (state == S_DIV_X && div_done) begin
      div_cmd.start    = 1'b1;
      div_cmd.dividend = sum_y_r;
      div_cmd.divisor  = cnt_r;
    end
  end

  lcacc_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_LABELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .raddr (in_idx[AW-1:0]),
    .rdata (ram_rbits)
  );

  lcacc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      next_order <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == S_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_LABELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            idx_r  <= in_idx[AW-1:0];
            in_x_r <= in_x;
            in_y_r <= in_y;
            unique case (s_tuser)
              lcacc_pkg::REQ_ACC: begin
                if (label_ok && frame_ok) begin
                  state <= S_ACC_WAIT;
                end
              end
              lcacc_pkg::REQ_READ: begin
                if (label_ok) begin
                  state <= S_RD_WAIT;
                end else begin
                  pres_r <= 1'b0;
                  ord_r  <= '0;
                  cnt_r  <= '0;
                  cx_r   <= '0;
                  cy_r   <= '0;
                  state  <= S_FIN;
                end
              end
              lcacc_pkg::REQ_CLEAR: begin
                clr_addr   <= '0;
                next_order <= '0;
                state      <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_ACC_WAIT: begin
          if (ram_rdata.count == '0) begin
            next_order <= next_order + OW'(1);
          end
          state <= S_IDLE;
        end
        S_RD_WAIT: begin
          sum_y_r <= ram_rdata.sum_y;
          cnt_r   <= ram_rdata.count;
          if (ram_rdata.count == '0) begin
            pres_r <= 1'b0;
            ord_r  <= '0;
            cx_r   <= '0;
            cy_r   <= '0;
            state  <= S_FIN;
          end else begin
            pres_r <= 1'b1;
            ord_r  <= ram_rdata.order;
            state  <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            cx_r  <= div_q;
            state <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_done) begin
            cy_r  <= div_q;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tuser  <= pres_r;
            m_tdata  <= {5'b0, cy_r, cx_r, cnt_r, ord_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
